### hw/rtl/date_time_field_editor_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the date and time field editor checker.
// ---------------------------------------------------------------------------
`ifndef DATE_TIME_FIELD_EDITOR_ASSERT_SVH
`define DATE_TIME_FIELD_EDITOR_ASSERT_SVH

// Clocked on i_clk, quiet while i_rst_n is low.
`define DTFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked on i_clk, also checked during reset.
`define DTFE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/dtfe_pkg.sv
// ---------------------------------------------------------------------------
// dtfe_pkg
// Types and constants shared by the date and time field editor.
// ---------------------------------------------------------------------------
package dtfe_pkg;

    localparam logic [11:0] YEAR_MIN = 12'd1970;
    localparam logic [11:0] YEAR_MAX = 12'd2100;

    // Odd-divisor test: y is a multiple of 25 exactly when y * inv(25) mod 2^12
    // lands at or below floor(4095 / 25).
    localparam logic [11:0] INV_25     = 12'd3113;
    localparam logic [11:0] DIV_25_MAX = 12'd163;

    localparam logic [2:0] POS_COUNT_24 = 3'd6;
    localparam logic [2:0] POS_COUNT_12 = 3'd7;

    typedef enum logic [2:0] {
        OP_UP     = 3'd0,
        OP_DOWN   = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_TOGGLE = 3'd4,
        OP_LOAD   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        POS_YEAR   = 3'd0,
        POS_MONTH  = 3'd1,
        POS_DAY    = 3'd2,
        POS_HOUR   = 3'd3,
        POS_MINUTE = 3'd4,
        POS_SECOND = 3'd5,
        POS_AMPM   = 3'd6
    } t_pos;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
        logic        load_mode_24;
    } t_in_item;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  cursor;
        logic        mode_24;
        logic        is_morning;
        logic [4:0]  display_hour;
    } t_out_item;

    localparam t_out_item RESET_ITEM = '{
        year:         YEAR_MIN,
        month:        4'd1,
        day:          5'd1,
        hour:         5'd0,
        minute:       6'd0,
        second:       6'd0,
        cursor:       POS_YEAR,
        mode_24:      1'b0,
        is_morning:   1'b1,
        display_hour: 5'd12
    };

endpackage

### hw/rtl/dtfe_in_if.sv
// ---------------------------------------------------------------------------
// dtfe_in_if
// Button event channel: valid, ready and one event beat.
// ---------------------------------------------------------------------------
interface dtfe_in_if;
    import dtfe_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/dtfe_out_if.sv
// ---------------------------------------------------------------------------
// dtfe_out_if
// Editor state channel: valid, ready and one result beat.
// ---------------------------------------------------------------------------
interface dtfe_out_if;
    import dtfe_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/dtfe_update.sv
// ---------------------------------------------------------------------------
// dtfe_update
// Applies one button event to the current state, then validates the fields.
// ---------------------------------------------------------------------------
module dtfe_update (
    input  dtfe_pkg::t_in_item  i_item,
    input  dtfe_pkg::t_out_item i_cur,
    output dtfe_pkg::t_out_item o_next
);
    import dtfe_pkg::*;

    always_comb begin
        logic [11:0]        y;
        logic [3:0]         mo;
        logic [5:0]         d;
        logic signed [6:0]  h;
        logic signed [6:0]  mi;
        logic signed [6:0]  s;
        logic [2:0]         cur;
        logic               m24;
        logic [2:0]         cnt;
        logic [3:0]         cur_inc;
        logic [11:0]        prod;
        logic               div25;
        logic               leap;
        logic [4:0]         len;
        logic [4:0]         hr;
        logic [4:0]         disp;

        y   = i_cur.year;
        mo  = i_cur.month;
        d   = {1'b0, i_cur.day};
        h   = signed'({2'b00, i_cur.hour});
        mi  = signed'({1'b0, i_cur.minute});
        s   = signed'({1'b0, i_cur.second});
        cur = i_cur.cursor;
        m24 = i_cur.mode_24;
        cnt = m24 ? POS_COUNT_24 : POS_COUNT_12;
        cur_inc = {1'b0, cur} + 4'd1;

        case (t_op'(i_item.op))
            OP_UP: begin
                case (t_pos'(cur))
                    POS_YEAR:   y  = y + 12'd1;
                    POS_MONTH:  mo = mo + 4'd1;
                    POS_DAY:    d  = d + 6'd1;
                    POS_HOUR:   h  = h + 7'sd1;
                    POS_MINUTE: mi = mi + 7'sd1;
                    POS_SECOND: s  = s + 7'sd1;
                    POS_AMPM:   h  = h + 7'sd12;
                    default: ;
                endcase
            end
            OP_DOWN: begin
                case (t_pos'(cur))
                    POS_YEAR:   y  = y - 12'd1;
                    POS_MONTH:  mo = mo - 4'd1;
                    POS_DAY:    d  = d - 6'd1;
                    POS_HOUR:   h  = h - 7'sd1;
                    POS_MINUTE: mi = mi - 7'sd1;
                    POS_SECOND: s  = s - 7'sd1;
                    POS_AMPM:   h  = h - 7'sd12;
                    default: ;
                endcase
            end
            OP_LEFT: begin
                cur = (cur == POS_YEAR) ? cnt - 3'd1 : cur - 3'd1;
            end
            OP_RIGHT: begin
                if (cur_inc >= {1'b0, cnt}) begin
                    cur = 3'(cur_inc - {1'b0, cnt});
                end else begin
                    cur = cur_inc[2:0];
                end
            end
            OP_TOGGLE: begin
                m24 = !m24;
                cnt = m24 ? POS_COUNT_24 : POS_COUNT_12;
                if (cur >= cnt) begin
                    cur = cur - cnt;
                end
            end
            OP_LOAD: begin
                y   = i_item.load_year;
                mo  = i_item.load_month;
                d   = {1'b0, i_item.load_day};
                h   = signed'({2'b00, i_item.load_hour});
                mi  = signed'({1'b0, i_item.load_minute});
                s   = signed'({1'b0, i_item.load_second});
                m24 = i_item.load_mode_24;
                cur = POS_YEAR;
            end
            default: ;
        endcase

        // Leap test runs on the year before it is clamped.
        prod  = y * INV_25;
        div25 = (prod <= DIV_25_MAX);
        leap  = ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);

        if (mo > 4'd12) begin
            mo = mo - 4'd12;
        end else if (mo == 4'd0) begin
            mo = 4'd12;
        end

        if (y > YEAR_MAX) begin
            y = YEAR_MAX;
        end else if (y < YEAR_MIN) begin
            y = YEAR_MIN;
        end

        case (mo)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase

        // Wrap the day once by the month length.
        if (d > {1'b0, len}) begin
            d = d - {1'b0, len};
        end else if (d == 6'd0) begin
            d = {1'b0, len};
        end

        if (h > 7'sd23) begin
            h = h - 7'sd24;
        end else if (h < 7'sd0) begin
            h = h + 7'sd24;
        end
        if (mi > 7'sd59) begin
            mi = mi - 7'sd60;
        end else if (mi < 7'sd0) begin
            mi = mi + 7'sd60;
        end
        if (s > 7'sd59) begin
            s = s - 7'sd60;
        end else if (s < 7'sd0) begin
            s = s + 7'sd60;
        end

        hr   = h[4:0];
        disp = hr;
        if (!m24) begin
            if (hr == 5'd0) begin
                disp = 5'd12;
            end else if (hr > 5'd12) begin
                disp = hr - 5'd12;
            end
        end

        o_next.year         = y;
        o_next.month        = mo;
        o_next.day          = d[4:0];
        o_next.hour         = hr;
        o_next.minute       = mi[5:0];
        o_next.second       = s[5:0];
        o_next.cursor       = cur;
        o_next.mode_24      = m24;
        o_next.is_morning   = (hr < 5'd12);
        o_next.display_hour = disp;
    end

endmodule

### hw/rtl/date_time_field_editor.sv
// An accepted event waits in the event register, then enters the result register once that slot is free.
// Throughput: one event per cycle while results are taken; event and result registers
// form a two-entry pipe, so input takes one more beat while a result waits, then stalls.
// The result register holds the editor state and updates only when its slot is free.
// Synchronous reset restores the minimum year, month 1, day 1, time zero,
// 12-hour mode and the cursor on the year, and empties both stages.
// ---------------------------------------------------------------------------
// date_time_field_editor
// Button-driven editor for a date and time, one event in, one state out.
// ---------------------------------------------------------------------------
module date_time_field_editor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtfe_in_if.sink     i_in,
    dtfe_out_if.source  o_out
);
    import dtfe_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      advance;

    // Move the held event into the result slot when that slot is free.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    dtfe_update u_update (
        .i_item (r_in),
        .i_cur  (r_out),
        .o_next (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= RESET_ITEM;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### hw/rtl/dtfe_checker.sv
// ---------------------------------------------------------------------------
// dtfe_checker
// Port-level checks on the date and time field editor, bound to the top.
// ---------------------------------------------------------------------------
`include "date_time_field_editor_assert.svh"

module dtfe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input dtfe_pkg::t_out_item i_out_data
);
    import dtfe_pkg::*;

    // A stalled result beat holds.
    `DTFE_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "result beat changed while stalled")

    // Reset empties the result slot.
    `DTFE_ASSERT_RST(a_rst_empty, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // Every accepted event is checked to show a result beat.
    `DTFE_ASSERT(a_in_to_out, i_in_valid && i_in_ready |-> ##2 i_out_valid, "accepted event gave no result")

    // Shown fields stay validated and consistent with each other.
    `DTFE_ASSERT(a_fields_ok, i_out_valid |-> i_out_data.year >= YEAR_MIN && i_out_data.year <= YEAR_MAX && i_out_data.month >= 4'd1 && i_out_data.month <= 4'd12 && i_out_data.day >= 5'd1 && i_out_data.hour <= 5'd23 && i_out_data.minute <= 6'd59 && i_out_data.second <= 6'd59 && i_out_data.cursor < (i_out_data.mode_24 ? POS_COUNT_24 : POS_COUNT_12) && i_out_data.is_morning == (i_out_data.hour < 5'd12), "result fields out of range")

endmodule

bind date_time_field_editor dtfe_checker u_dtfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
